// ===== hdl/sprite_frame_sequencer_assert.svh =====
// assertion helpers for the sprite frame sequencer
`ifndef SPRITE_FRAME_SEQUENCER_ASSERT_SVH
`define SPRITE_FRAME_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define SFS_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sfs_pkg.sv =====
`default_nettype none

package sfs_pkg;

    localparam int MAX_FRAMES  = 256;
    localparam int FRAME_W     = 8;
    localparam int TOTAL_W     = 9;
    localparam int POS_W       = 9;
    localparam int LEN_W       = 10;
    localparam int ACC_W       = 32;
    localparam int IVL_W       = 24;
    localparam int ELAPSED_W   = 24;
    localparam int FUNC_W      = 3;
    localparam int COLS_W      = 9;
    localparam int DIM_W       = 12;
    localparam int COORD_W     = 20;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam int DIV_STEPS   = 4;
    localparam int DIV_CYCLES  = FRAME_W / DIV_STEPS;
    localparam int DIV_CNT_W   = 1;

    localparam int MAX_IN_FLIGHT = 5;
    localparam int FLIGHT_W      = 3;

    localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_START  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_STOP   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_PAUSE  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_RESUME = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 3'd7;

    localparam logic [IVL_W-1:0] INTERVAL_RESET = 24'd1024;

    localparam int MODE_LOOP_BIT     = 0;
    localparam int MODE_PINGPONG_BIT = 1;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [POS_W-1:0]   position;
        logic               playing;
    } t_item;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [FRAME_W-1:0] first;
        logic [TOTAL_W-1:0] fwd_len;
        logic [LEN_W-1:0]   list_len;
        logic               loop_en;
        logic [IVL_W-1:0]   interval;
    } t_play_cfg;

    typedef struct packed {
        logic [COLS_W-1:0] columns;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
    } t_geom_cfg;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_ADD,
        FR_STEP,
        FR_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_MUL
    } t_back_state;

endpackage

`default_nettype wire

// ===== hdl/sfs_cfg.sv =====
`default_nettype none

module sfs_cfg import sfs_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_play_cfg                  o_play,
    output t_geom_cfg                  o_geom
);

    logic [COLS_W-1:0]  r_columns;
    logic [TOTAL_W-1:0] r_total;
    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    logic [FRAME_W-1:0] r_start;
    logic [FRAME_W-1:0] r_end;
    logic [MODE_W-1:0]  r_mode;
    logic [IVL_W-1:0]   r_interval;

    logic [TOTAL_W-1:0] tot;
    logic [FRAME_W-1:0] first;
    logic [FRAME_W-1:0] last;
    logic [TOTAL_W-1:0] fwd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns  <= COLS_W'(1);
            r_total    <= TOTAL_W'(1);
            r_width    <= DIM_W'(1);
            r_height   <= DIM_W'(1);
            r_start    <= '0;
            r_end      <= '0;
            r_mode     <= '0;
            r_interval <= INTERVAL_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COLUMNS:  r_columns  <= i_cfg_data[COLS_W-1:0];
                CFG_TOTAL:    r_total    <= i_cfg_data[TOTAL_W-1:0];
                CFG_WIDTH:    r_width    <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT:   r_height   <= i_cfg_data[DIM_W-1:0];
                CFG_START:    r_start    <= i_cfg_data[FRAME_W-1:0];
                CFG_END:      r_end      <= i_cfg_data[FRAME_W-1:0];
                CFG_MODE:     r_mode     <= i_cfg_data[MODE_W-1:0];
                CFG_INTERVAL: r_interval <= i_cfg_data[IVL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // effective range of the play list
    always_comb begin
        if (r_total == '0) begin
            tot = TOTAL_W'(1);
        end else if (r_total > TOTAL_W'(MAX_FRAMES)) begin
            tot = TOTAL_W'(MAX_FRAMES);
        end else begin
            tot = r_total;
        end
        first = ({1'b0, r_start} >= tot) ? FRAME_W'(tot - TOTAL_W'(1)) : r_start;
        last  = ({1'b0, r_end} >= tot) ? FRAME_W'(tot - TOTAL_W'(1)) : r_end;
        if (first <= last) begin
            fwd = {1'b0, last} - {1'b0, first} + TOTAL_W'(1);
        end else begin
            fwd = tot - {1'b0, first} + {1'b0, last} + TOTAL_W'(1);
        end
    end

    always_comb begin
        o_play.total    = tot;
        o_play.first    = first;
        o_play.fwd_len  = fwd;
        o_play.list_len = r_mode[MODE_PINGPONG_BIT] ? {fwd, 1'b0} : {1'b0, fwd};
        o_play.loop_en  = r_mode[MODE_LOOP_BIT];
        o_play.interval = (r_interval == '0) ? IVL_W'(1) : r_interval;
        o_geom.columns  = (r_columns == '0) ? COLS_W'(1) : r_columns;
        o_geom.width    = r_width;
        o_geom.height   = r_height;
    end

endmodule

`default_nettype wire

// ===== hdl/sfs_front.sv =====
`default_nettype none

module sfs_front import sfs_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [FUNC_W-1:0]    i_func,
    input  wire logic [ELAPSED_W-1:0] i_elapsed,
    input  wire t_play_cfg            i_play,
    input  wire logic                 i_full,
    output logic                      o_push,
    output t_item                     o_item
);

    t_front_state r_state, n_state;
    logic [FUNC_W-1:0]    r_func;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic                 r_running, n_running;

    logic [ACC_W:0]       sum;
    logic [LEN_W-1:0]     step_next;
    logic [LEN_W-1:0]     clamp_pos;
    logic [LEN_W-1:0]     half_pos;
    logic [LEN_W-1:0]     sheet_pos;

    always_comb begin
        n_state = r_state;
        case (r_state)
            FR_IDLE: if (i_valid) n_state = FR_ADD;
            FR_ADD:  n_state = FR_STEP;
            FR_STEP: n_state = FR_PUSH;
            FR_PUSH: if (!i_full) n_state = FR_IDLE;
            default: n_state = FR_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_push  = 1'b0;
        case (r_state)
            FR_IDLE: o_ready = 1'b1;
            FR_PUSH: o_push  = !i_full;
            default: begin
            end
        endcase
    end

    // accumulate and advance
    always_comb begin
        sum       = {1'b0, r_acc} + (ACC_W + 1)'(r_elapsed);
        step_next = LEN_W'(r_pos) + LEN_W'(1);
        n_acc     = r_acc;
        n_pos     = r_pos;
        n_running = r_running;
        case (r_state)
            FR_ADD: begin
                case (r_func)
                    FUNC_TICK: begin
                        if (r_running) n_acc = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
                    end
                    FUNC_START: begin
                        n_pos     = '0;
                        n_running = 1'b1;
                    end
                    FUNC_STOP: begin
                        n_pos     = '0;
                        n_running = 1'b0;
                    end
                    FUNC_PAUSE:  n_running = 1'b0;
                    FUNC_RESUME: n_running = 1'b1;
                    default: begin
                    end
                endcase
            end
            FR_STEP: begin
                if (r_func == FUNC_TICK && r_running
                        && r_acc >= ACC_W'(i_play.interval)) begin
                    n_acc = r_acc - ACC_W'(i_play.interval);
                    if (step_next >= i_play.list_len) begin
                        if (i_play.loop_en) begin
                            n_pos = '0;
                        end else begin
                            n_pos     = POS_W'(i_play.list_len - LEN_W'(1));
                            n_running = 1'b0;
                        end
                    end else begin
                        n_pos = step_next[POS_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // list position to sheet frame
    always_comb begin
        clamp_pos = ({1'b0, r_pos} >= i_play.list_len) ?
                    i_play.list_len - LEN_W'(1) : {1'b0, r_pos};
        half_pos  = (clamp_pos >= LEN_W'(i_play.fwd_len)) ?
                    {i_play.fwd_len, 1'b0} - LEN_W'(1) - clamp_pos : clamp_pos;
        sheet_pos = LEN_W'(i_play.first) + half_pos;
        if (sheet_pos >= LEN_W'(i_play.total)) sheet_pos = sheet_pos - LEN_W'(i_play.total);
        o_item.frame    = sheet_pos[FRAME_W-1:0];
        o_item.position = r_pos;
        o_item.playing  = r_running;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= FR_IDLE;
            r_acc     <= '0;
            r_pos     <= '0;
            r_running <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_acc     <= n_acc;
            r_pos     <= n_pos;
            r_running <= n_running;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_func    <= i_func;
            r_elapsed <= i_elapsed;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sfs_fifo.sv =====
`default_nettype none

module sfs_fifo import sfs_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_item      o_item
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_item;
    end

endmodule

`default_nettype wire

// ===== hdl/sfs_back.sv =====
`default_nettype none

module sfs_back import sfs_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_geom_cfg     i_geom,
    input  wire logic          i_empty,
    input  wire t_item         i_item,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [FRAME_W-1:0] o_frame_index,
    output logic [COORD_W-1:0] o_frame_x,
    output logic [COORD_W-1:0] o_frame_y,
    output logic [POS_W-1:0]   o_play_position,
    output logic               o_playing
);

    t_back_state r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [FRAME_W-1:0]   r_dvd, n_dvd;
    logic [FRAME_W-1:0]   r_quo, n_quo;
    logic [COLS_W-1:0]    r_rem, n_rem;
    logic [FRAME_W-1:0]   r_frame;
    logic [POS_W-1:0]     r_pos;
    logic                 r_play;

    logic                 r_out_valid;
    logic [FRAME_W-1:0]   r_out_frame;
    logic [COORD_W-1:0]   r_out_x;
    logic [COORD_W-1:0]   r_out_y;
    logic [POS_W-1:0]     r_out_pos;
    logic                 r_out_play;

    logic                 out_free;
    logic                 out_load;
    logic [COORD_W-1:0]   prod_x;
    logic [COORD_W-1:0]   prod_y;

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: if (!i_empty) n_state = BK_DIV;
            BK_DIV:  if (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) n_state = BK_MUL;
            BK_MUL:  if (out_free) n_state = i_empty ? BK_IDLE : BK_DIV;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        out_load = 1'b0;
        case (r_state)
            BK_IDLE: o_pop = !i_empty;
            BK_MUL: begin
                out_load = out_free;
                o_pop    = out_free && !i_empty;
            end
            default: begin
            end
        endcase
    end

    // restoring division of the frame by the column count
    always_comb begin
        logic [COLS_W:0] trial;
        n_dvd = r_dvd;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int k = 0; k < DIV_STEPS; k++) begin
            trial = {n_rem, n_dvd[FRAME_W-1]};
            n_dvd = {n_dvd[FRAME_W-2:0], 1'b0};
            if (trial >= {1'b0, i_geom.columns}) begin
                n_rem = COLS_W'(trial - {1'b0, i_geom.columns});
                n_quo = {n_quo[FRAME_W-2:0], 1'b1};
            end else begin
                n_rem = trial[COLS_W-1:0];
                n_quo = {n_quo[FRAME_W-2:0], 1'b0};
            end
        end
    end

    assign prod_x = COORD_W'(r_rem) * COORD_W'(i_geom.width);
    assign prod_y = COORD_W'(r_quo) * COORD_W'(i_geom.height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_cnt <= '0;
            end else if (r_state == BK_DIV) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_dvd   <= i_item.frame;
            r_quo   <= '0;
            r_rem   <= '0;
            r_frame <= i_item.frame;
            r_pos   <= i_item.position;
            r_play  <= i_item.playing;
        end else if (r_state == BK_DIV) begin
            r_dvd <= n_dvd;
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
        if (out_load) begin
            r_out_frame <= r_frame;
            r_out_x     <= prod_x;
            r_out_y     <= prod_y;
            r_out_pos   <= r_pos;
            r_out_play  <= r_play;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_frame_index   = r_out_frame;
    assign o_frame_x       = r_out_x;
    assign o_frame_y       = r_out_y;
    assign o_play_position = r_out_pos;
    assign o_playing       = r_out_play;

endmodule

`default_nettype wire

// ===== hdl/sprite_frame_sequencer.sv =====
// Sprite-sheet animation player. Each accepted command (tick, start, stop, pause,
// resume) yields exactly one result with the shown frame, its pixel position on
// the sheet, the play position and the playing flag. The command sequencer
// handles one item at a time in steps (accept, accumulate, advance, hand-over)
// and takes no new command until its hand-over, which waits on a full queue.
// A two-entry queue feeds the coordinate unit, which divides the frame by the
// column count at four quotient bits per cycle, then multiplies into the output
// register. Configuration registers are written by index and are taken at once;
// write them only when no result is outstanding.
`default_nettype none

module sprite_frame_sequencer import sfs_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [FUNC_W-1:0]     i_func,
    input  wire logic [ELAPSED_W-1:0]  i_elapsed,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [FRAME_W-1:0]         o_frame_index,
    output logic [COORD_W-1:0]         o_frame_x,
    output logic [COORD_W-1:0]         o_frame_y,
    output logic [POS_W-1:0]           o_play_position,
    output logic                       o_playing
);

    t_play_cfg play_cfg;
    t_geom_cfg geom_cfg;
    t_item     front_item;
    t_item     queue_item;
    logic      push;
    logic      pop;
    logic      full;
    logic      empty;

    sfs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_play      (play_cfg),
        .o_geom      (geom_cfg)
    );

    sfs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_func    (i_func),
        .i_elapsed (i_elapsed),
        .i_play    (play_cfg),
        .i_full    (full),
        .o_push    (push),
        .o_item    (front_item)
    );

    sfs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (queue_item)
    );

    sfs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_geom          (geom_cfg),
        .i_empty         (empty),
        .i_item          (queue_item),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_frame_index   (o_frame_index),
        .o_frame_x       (o_frame_x),
        .o_frame_y       (o_frame_y),
        .o_play_position (o_play_position),
        .o_playing       (o_playing)
    );

endmodule

`default_nettype wire

// ===== hdl/sfs_checker.sv =====
`default_nettype none

`include "sprite_frame_sequencer_assert.svh"

module sfs_checker import sfs_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic                  o_ready,
    input  wire logic                  o_valid,
    input  wire logic                  i_ready,
    input  wire logic [FRAME_W-1:0]    o_frame_index,
    input  wire logic [COORD_W-1:0]    o_frame_x,
    input  wire logic [COORD_W-1:0]    o_frame_y,
    input  wire logic [POS_W-1:0]      o_play_position
);

    logic [FLIGHT_W-1:0] r_outstanding;
    logic                in_xfer;
    logic                out_xfer;

    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = o_valid && i_ready;

    // items accepted whose result has not been taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else if (in_xfer && !out_xfer) begin
            r_outstanding <= r_outstanding + FLIGHT_W'(1);
        end else if (out_xfer && !in_xfer) begin
            r_outstanding <= r_outstanding - FLIGHT_W'(1);
        end
    end

    `SFS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_frame_index) && $stable(o_play_position), "result changed before transfer")
    `SFS_ASSERT_IMPLY(a_frame_zero, i_clk, i_rst_n, o_valid && o_frame_index == '0, o_frame_x == '0 && o_frame_y == '0, "frame zero not at sheet origin")
    `SFS_ASSERT_IMPLY(a_no_spurious, i_clk, i_rst_n, out_xfer, r_outstanding != '0 || in_xfer, "result without accepted item")
    `SFS_ASSERT_IMPLY(a_in_flight, i_clk, i_rst_n, 1'b1, r_outstanding <= FLIGHT_W'(MAX_IN_FLIGHT), "too many items in flight")

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_sprite_frame_sequencer.sv =====
`timescale 1ns / 1ps

module tb_sprite_frame_sequencer;
    import sfs_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 20;
    localparam int unsigned REPORT_LIMIT   = 100;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

    localparam logic [MODE_W-1:0] PLAY_ONCE        = 2'b00;
    localparam logic [MODE_W-1:0] PLAY_LOOP        = 2'b01;
    localparam logic [MODE_W-1:0] PLAY_BOUNCE      = 2'b10;
    localparam logic [MODE_W-1:0] PLAY_BOUNCE_LOOP = 2'b11;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_index;
        logic [COORD_W-1:0] frame_x;
        logic [COORD_W-1:0] frame_y;
        logic [POS_W-1:0]   play_position;
        logic               playing;
    } t_frame_result;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] columns;
        logic [CFG_DATA_W-1:0] total;
        logic [CFG_DATA_W-1:0] width;
        logic [CFG_DATA_W-1:0] height;
        logic [CFG_DATA_W-1:0] first;
        logic [CFG_DATA_W-1:0] last;
        logic [CFG_DATA_W-1:0] mode;
        logic [CFG_DATA_W-1:0] interval;
    } t_sheet_setup;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [FUNC_W-1:0]     i_func = '0;
    logic [ELAPSED_W-1:0]  i_elapsed = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [FRAME_W-1:0]    o_frame_index;
    logic [COORD_W-1:0]    o_frame_x;
    logic [COORD_W-1:0]    o_frame_y;
    logic [POS_W-1:0]      o_play_position;
    logic                  o_playing;

    // copy of the registers, reset values
    logic [COLS_W-1:0]  sheet_cols = COLS_W'(1);
    logic [TOTAL_W-1:0] sheet_total = TOTAL_W'(1);
    logic [DIM_W-1:0]   frame_width = DIM_W'(1);
    logic [DIM_W-1:0]   frame_height = DIM_W'(1);
    logic [FRAME_W-1:0] range_first = '0;
    logic [FRAME_W-1:0] range_last = '0;
    logic [MODE_W-1:0]  play_mode = PLAY_ONCE;
    logic [IVL_W-1:0]   frame_interval = INTERVAL_RESET;

    // player state
    logic [ACC_W-1:0]   accum = '0;
    logic [POS_W-1:0]   play_pos = '0;
    logic               running = 1'b0;

    t_frame_result frames_due[$];
    int unsigned   mismatches = 0;
    int unsigned   idle_pct = 20;
    int unsigned   stall_left = 0;
    int unsigned   quiet_cycles = 0;

    sprite_frame_sequencer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_elapsed       (i_elapsed),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_frame_index   (o_frame_index),
        .o_frame_x       (o_frame_x),
        .o_frame_y       (o_frame_y),
        .o_play_position (o_play_position),
        .o_playing       (o_playing)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned sheet_frames();
        int unsigned t = (sheet_total == 0) ? 1 : sheet_total;
        return (t > MAX_FRAMES) ? MAX_FRAMES : t;
    endfunction

    function automatic int unsigned clamp_frame(input int unsigned v, input int unsigned t);
        return (v >= t) ? t - 1 : v;
    endfunction

    function automatic int unsigned forward_length();
        int unsigned t = sheet_frames();
        int unsigned s = clamp_frame(range_first, t);
        int unsigned e = clamp_frame(range_last, t);
        return (s <= e) ? e - s + 1 : t - s + e + 1;
    endfunction

    function automatic void store_register(input logic [CFG_IDX_W-1:0] index,
                                           input logic [CFG_DATA_W-1:0] data);
        case (index)
            CFG_COLUMNS:  sheet_cols     = data[COLS_W-1:0];
            CFG_TOTAL:    sheet_total    = data[TOTAL_W-1:0];
            CFG_WIDTH:    frame_width    = data[DIM_W-1:0];
            CFG_HEIGHT:   frame_height   = data[DIM_W-1:0];
            CFG_START:    range_first    = data[FRAME_W-1:0];
            CFG_END:      range_last     = data[FRAME_W-1:0];
            CFG_MODE:     play_mode      = data[MODE_W-1:0];
            CFG_INTERVAL: frame_interval = data[IVL_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic t_frame_result advance_player(input logic [FUNC_W-1:0] func,
                                                     input logic [ELAPSED_W-1:0] elapsed);
        int unsigned frames = sheet_frames();
        int unsigned fwd = forward_length();
        int unsigned len = play_mode[MODE_PINGPONG_BIT] ? 2 * fwd : fwd;
        int unsigned step_size = (frame_interval == 0) ? 1 : frame_interval;
        int unsigned cols = (sheet_cols == 0) ? 1 : sheet_cols;
        int unsigned next, shown, frame;
        logic [ACC_W:0] sum;
        t_frame_result r;
        case (func)
            FUNC_TICK: begin
                if (running) begin
                    sum = {1'b0, accum} + elapsed;
                    accum = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
                    if (accum >= step_size) begin
                        next = play_pos + 1;
                        if (next >= len) begin
                            if (play_mode[MODE_LOOP_BIT]) begin
                                next = 0;
                            end else begin
                                next = len - 1;
                                running = 1'b0;
                            end
                        end
                        play_pos = POS_W'(next);
                        accum = accum - step_size;
                    end
                end
            end
            FUNC_START: begin
                play_pos = '0;
                running = 1'b1;
            end
            FUNC_STOP: begin
                play_pos = '0;
                running = 1'b0;
            end
            FUNC_PAUSE:  running = 1'b0;
            FUNC_RESUME: running = 1'b1;
            default: ;
        endcase
        shown = (play_pos >= len) ? len - 1 : play_pos;
        // second half of a ping-pong list walks back
        if (shown >= fwd) shown = 2 * fwd - 1 - shown;
        frame = clamp_frame(range_first, frames) + shown;
        if (frame >= frames) frame -= frames;
        r.frame_index = FRAME_W'(frame);
        r.frame_x = COORD_W'((frame % cols) * frame_width);
        r.frame_y = COORD_W'((frame / cols) * frame_height);
        r.play_position = play_pos;
        r.playing = running;
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_frame_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) store_register(i_cfg_index, i_cfg_data);
            if (i_valid && o_ready) frames_due = {frames_due, advance_player(i_func, i_elapsed)};
            if (o_valid && i_ready) begin
                if (frames_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result with none pending, expected none, actual frame %0d",
                                 $time, o_frame_index);
                end else begin
                    want = frames_due.pop_front();
                    check_field("frame_index", want.frame_index, o_frame_index);
                    check_field("frame_x", want.frame_x, o_frame_x);
                    check_field("frame_y", want.frame_y, o_frame_y);
                    check_field("play_position", want.play_position, o_play_position);
                    check_field("playing", want.playing, o_playing);
                end
            end
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            stall_left <= $urandom_range(0, 2);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("** sprite_frame_sequencer: FAILED **");
            $finish;
        end
    end

    task automatic send_command(input logic [FUNC_W-1:0] func,
                                input logic [ELAPSED_W-1:0] elapsed);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= func;
        i_elapsed <= elapsed;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (frames_due.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic apply_setup(input t_sheet_setup s);
        drain_results();
        write_register(CFG_COLUMNS, s.columns);
        write_register(CFG_TOTAL, s.total);
        write_register(CFG_WIDTH, s.width);
        write_register(CFG_HEIGHT, s.height);
        write_register(CFG_START, s.first);
        write_register(CFG_END, s.last);
        write_register(CFG_MODE, s.mode);
        write_register(CFG_INTERVAL, s.interval);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_sheet_setup make_setup(input int unsigned cols, input int unsigned total,
                                                input int unsigned width,
                                                input int unsigned height,
                                                input int unsigned first, input int unsigned last,
                                                input int unsigned mode,
                                                input int unsigned interval);
        t_sheet_setup s;
        s.columns = CFG_DATA_W'(cols);
        s.total = CFG_DATA_W'(total);
        s.width = CFG_DATA_W'(width);
        s.height = CFG_DATA_W'(height);
        s.first = CFG_DATA_W'(first);
        s.last = CFG_DATA_W'(last);
        s.mode = CFG_DATA_W'(mode);
        s.interval = CFG_DATA_W'(interval);
        return s;
    endfunction

    // junk above the register width now and then
    function automatic logic [CFG_DATA_W-1:0] with_noise(input int unsigned value,
                                                         input int unsigned width);
        logic [CFG_DATA_W-1:0] v = CFG_DATA_W'(value);
        if ($urandom_range(0, 3) == 0) v = v | (CFG_DATA_W'($urandom) << width);
        return v;
    endfunction

    task automatic run_random_phase(input int unsigned count);
        t_sheet_setup s;
        int unsigned cols, total, width, height, limit, interval, iv, span, r;
        logic [FUNC_W-1:0] func;
        logic [ELAPSED_W-1:0] elapsed;
        case ($urandom_range(0, 7))
            0: cols = 0;
            1: cols = 1;
            2: cols = MAX_FRAMES;
            3: cols = $urandom_range(MAX_FRAMES + 1, 511);
            default: cols = $urandom_range(2, 16);
        endcase
        case ($urandom_range(0, 7))
            0: total = 0;
            1: total = 1;
            2: total = MAX_FRAMES;
            3: total = $urandom_range(MAX_FRAMES + 1, 511);
            default: total = $urandom_range(2, 48);
        endcase
        case ($urandom_range(0, 5))
            0: width = 0;
            1: width = 4095;
            default: width = $urandom_range(1, 4095);
        endcase
        case ($urandom_range(0, 5))
            0: height = 0;
            1: height = 4095;
            default: height = $urandom_range(1, 4095);
        endcase
        case ($urandom_range(0, 7))
            0: interval = 0;
            1: interval = 1;
            2: interval = 24'hFFFFFF;
            3: interval = $urandom & 24'hFFFFFF;
            default: interval = $urandom_range(1, 4096);
        endcase
        iv = (interval == 0) ? 1 : interval;
        limit = (total >= 1 && total <= MAX_FRAMES) ? total - 1 : MAX_FRAMES - 1;
        s.columns = with_noise(cols, COLS_W);
        s.total = with_noise(total, TOTAL_W);
        s.width = with_noise(width, DIM_W);
        s.height = with_noise(height, DIM_W);
        s.first = with_noise(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(0, limit), FRAME_W);
        s.last = with_noise(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, limit), FRAME_W);
        s.mode = with_noise($urandom_range(0, 3), MODE_W);
        s.interval = CFG_DATA_W'(interval);
        apply_setup(s);
        if ($urandom_range(0, 4) != 0) send_command(FUNC_START, ELAPSED_W'($urandom));
        repeat (count) begin
            r = $urandom_range(0, 99);
            elapsed = ELAPSED_W'($urandom);
            if (r < 78) begin
                func = FUNC_TICK;
                case ($urandom_range(0, 9))
                    0: elapsed = '0;
                    1: elapsed = '1;
                    2: ;
                    3: elapsed = ELAPSED_W'(iv);
                    default: begin
                        span = $urandom_range(0, 2 * iv);
                        elapsed = (span >> ELAPSED_W) != 0 ? '1 : ELAPSED_W'(span);
                    end
                endcase
            end else if (r < 82) begin
                func = FUNC_START;
            end else if (r < 86) begin
                func = FUNC_STOP;
            end else if (r < 90) begin
                func = FUNC_PAUSE;
            end else if (r < 94) begin
                func = FUNC_RESUME;
            end else if (r < 97) begin
                func = FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
            end else begin
                func = FUNC_W'($urandom);
            end
            send_command(func, elapsed);
        end
    endtask

    task automatic test_reset_defaults();
        send_command(FUNC_TICK, '1);
        send_command(FUNC_START, '0);
        send_command(FUNC_TICK, ELAPSED_W'(1023));
        send_command(FUNC_TICK, ELAPSED_W'(1));
        send_command(FUNC_RESUME, '0);
        send_command(FUNC_TICK, ELAPSED_W'(1024));
        send_command(FUNC_UNUSED_LO, '1);
        send_command(FUNC_UNUSED_HI, '0);
        send_command(FUNC_STOP, '0);
    endtask

    task automatic test_range_shrink();
        int looped;
        logic [MODE_W-1:0] mode;
        for (looped = 0; looped < 2; looped++) begin
            mode = looped ? PLAY_LOOP : PLAY_ONCE;
            apply_setup(make_setup(4, 16, 10, 20, 0, 15, mode, 1));
            send_command(FUNC_START, '0);
            repeat (5) send_command(FUNC_TICK, ELAPSED_W'(1));
            // list cut to three entries while sitting past its end
            apply_setup(make_setup(4, 16, 10, 20, 0, 2, mode, 1));
            send_command(FUNC_TICK, '0);
            send_command(FUNC_TICK, ELAPSED_W'(1));
        end
    endtask

    task automatic test_sheet_extremes();
        apply_setup(make_setup(MAX_FRAMES, MAX_FRAMES, 4095, 4095, 250, 5, PLAY_BOUNCE_LOOP, 1));
        send_command(FUNC_START, '0);
        send_command(FUNC_TICK, '0);
        send_command(FUNC_TICK, '1);
        send_command(FUNC_PAUSE, '0);
        send_command(FUNC_TICK, ELAPSED_W'(1));
        send_command(FUNC_RESUME, '1);
        send_command(FUNC_TICK, ELAPSED_W'(1));
        // zero columns, total and interval behave as one
        apply_setup(make_setup(0, 0, 0, 4095, 255, 255, PLAY_ONCE, 0));
        send_command(FUNC_START, '0);
        send_command(FUNC_TICK, '0);
        send_command(FUNC_TICK, ELAPSED_W'(1));
        // oversized total, wrapped range, mirrored half, then stop
        apply_setup(make_setup(3, 511, 17, 9, 255, 0, PLAY_BOUNCE, 1024));
        send_command(FUNC_START, '0);
        repeat (4) send_command(FUNC_TICK, ELAPSED_W'(1000));
        send_command(FUNC_STOP, '0);
        send_command(FUNC_TICK, ELAPSED_W'(5000));
    endtask

    task automatic test_accumulator_saturation();
        apply_setup(make_setup(8, 64, 16, 16, 60, 3, PLAY_LOOP, 1));
        send_command(FUNC_START, '0);
        repeat (270) send_command(FUNC_TICK, '1);
        repeat (10) send_command(FUNC_TICK, ELAPSED_W'($urandom));
        // bleed the saturated total off through the longest interval
        apply_setup(make_setup(8, 64, 16, 16, 60, 3, PLAY_BOUNCE, 24'hFFFFFF));
        repeat (20) send_command(FUNC_TICK, '0);
    endtask

    task automatic test_random_play();
        repeat (10) begin
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 15;
                default: idle_pct = 40;
            endcase
            run_random_phase($urandom_range(80, 120));
        end
    endtask

    task automatic test_final_stretch();
        idle_pct = 0;
        run_random_phase(100);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_range_shrink();
        test_sheet_extremes();
        test_accumulator_saturation();
        test_random_play();
        test_final_stretch();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("** sprite_frame_sequencer: PASSED **");
        end else begin
            $display("** sprite_frame_sequencer: FAILED **");
        end
        $finish;
    end

endmodule
